### rtl/tto_pkg.sv
`default_nettype none

package tto_pkg;

    // One byte of a packet's option area, as it sits in the input register.
    typedef struct packed {
        logic [7:0] opt_byte;
        logic       first_byte;
        logic [5:0] area_len;
    } tto_item_t;

    // One parse result per packet.
    typedef struct packed {
        logic        found;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
    } tto_result_t;

endpackage

`default_nettype wire

### rtl/tto_if.sv
`default_nettype none

// Input channel: one option-area byte per transfer.
interface tto_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       first_byte;
    logic [5:0] area_len;

    modport source (output valid, output opt_byte, output first_byte, output area_len,
                    input ready);
    modport sink   (input valid, input opt_byte, input first_byte, input area_len,
                    output ready);
endinterface

// Output channel: one parse result per packet.
interface tto_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;

    modport source (output valid, output found, output ts_value, output ts_echo,
                    input ready);
    modport sink   (input valid, input found, input ts_value, input ts_echo,
                    output ready);
endinterface

`default_nettype wire

### rtl/tto_in_stage.sv
`default_nettype none

module tto_in_stage
    import tto_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tto_item_t in_item,
    input  wire logic      take,
    output logic           item_valid,
    output tto_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    tto_item_t item_reg;

    // The register may refill in the same cycle that the parser consumes it.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/tto_parser.sv
`default_nettype none

module tto_parser
    import tto_pkg::*;
#(
    parameter int unsigned MAX_AREA = 40
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire tto_item_t item,
    output logic           take,
    output logic           res_valid,
    input  wire logic      res_ready,
    output tto_result_t    res
);

    localparam logic [7:0] KIND_EOL   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_TS    = 8'd8;
    localparam logic [7:0] TS_LEN     = 8'd10;
    localparam logic [7:0] MIN_LEN    = 8'd2;
    localparam logic [5:0] AREA_LIMIT = 6'(MAX_AREA);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KIND,
        PH_LEN_OTH,
        PH_LEN_TS,
        PH_SKIP,
        PH_GATHER,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [5:0]  rem_reg,    rem_next;
    logic [5:0]  skip_reg,   skip_next;
    logic [55:0] gath_reg,   gath_next;
    logic [2:0]  gc_reg,     gc_next;
    logic        res_valid_reg, res_valid_next;
    tto_result_t res_reg,    res_next;

    logic        emit;
    logic [5:0]  rem_cur;
    logic [5:0]  rem_dec;
    logic [5:0]  rem_after;
    logic [5:0]  skip_len;
    logic [5:0]  skip_dec;
    logic [7:0]  b;

    // The parser steps whenever it holds a byte and the result register has room for a result.
    assign take = item_valid && (!res_valid_reg || res_ready);
    assign b    = item.opt_byte;

    assign rem_cur   = item.first_byte
                       ? ((item.area_len > AREA_LIMIT) ? AREA_LIMIT : item.area_len)
                       : rem_reg;
    assign rem_dec   = rem_cur - 6'd1;
    assign rem_after = rem_reg - b[5:0];
    assign skip_len  = b[5:0] - MIN_LEN[5:0];
    assign skip_dec  = skip_reg - 6'd1;

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        skip_next  = skip_reg;
        gath_next  = gath_reg;
        gc_next    = gc_reg;
        emit       = 1'b0;
        res_next   = '0;

        if (take)
        begin
            if (item.first_byte)
            begin
                rem_next  = rem_cur;
                skip_next = '0;
                gath_next = '0;
                gc_next   = '0;
            end

            if (item.first_byte && (rem_cur == 6'd0))
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
            else if (item.first_byte || (phase_reg == PH_KIND))
            begin
                priority if (b == KIND_EOL)
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (b == KIND_NOP)
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 6'd0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_KIND;
                    end
                end
                else if (rem_cur < 6'd2)
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (b == KIND_TS) ? PH_LEN_TS : PH_LEN_OTH;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN_OTH, PH_LEN_TS:
                    begin
                        priority if ((b < MIN_LEN) || (b > {2'b00, rem_reg}))
                        begin
                            emit       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if ((phase_reg == PH_LEN_TS) && (b == TS_LEN))
                        begin
                            gath_next  = '0;
                            gc_next    = '0;
                            phase_next = PH_GATHER;
                        end
                        else
                        begin
                            rem_next  = rem_after;
                            skip_next = skip_len;
                            priority if (skip_len != 6'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if (rem_after == 6'd0)
                            begin
                                emit       = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KIND;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 6'd0)
                        begin
                            if (rem_reg == 6'd0)
                            begin
                                emit       = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KIND;
                            end
                        end
                    end
                    PH_GATHER:
                    begin
                        gath_next = {gath_reg[47:0], b};
                        if (gc_reg == 3'd7)
                        begin
                            emit              = 1'b1;
                            res_next.found    = 1'b1;
                            res_next.ts_value = gath_reg[55:24];
                            res_next.ts_echo  = {gath_reg[23:0], b};
                            gc_next           = '0;
                            phase_next        = PH_DONE;
                        end
                        else
                        begin
                            gc_next = gc_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        // Idle or already decided: the byte is dropped.
                    end
                endcase
            end
        end

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            skip_reg      <= '0;
            gath_reg      <= '0;
            gc_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            skip_reg      <= skip_next;
            gath_reg      <= gath_next;
            gc_reg        <= gc_next;
            res_valid_reg <= res_valid_next;
            if (emit)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/tcp_timestamp_option_parser_top.sv
`default_nettype none

// TCP timestamp option parser.
// in_ch carries the TCP option area one byte per transfer. The first byte of a
// packet has first_byte set and area_len giving the option area size; an empty
// area is sent as a single dummy transfer with first_byte set and area_len zero.
// out_ch carries at most one result per packet: found with the timestamp value
// and echo reply words, or not found with both words zero. The result is made
// at the byte that decides it, and the rest of that packet's bytes are dropped.
// A new first byte abandons an unfinished packet without a result.
// A deciding byte passes the input register and then the result register before
// its result is offered on out_ch.
// Throughput: one byte per cycle while out_ch takes results, set by the single
// parser state update between the input register and the result register.
// When out_ch stalls, the held result blocks the parser; an empty input register
// still takes one more byte, then in_ch.ready drops until the result leaves.
// While the input register is full, in_ch.ready is high when the result register is empty or out_ch.ready is high.
// Reset is asynchronous and active low: both registers empty, parser idle and
// waiting for a first byte.
module tcp_timestamp_option_parser_top
    import tto_pkg::*;
#(
    parameter int unsigned MAX_AREA = 40
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tto_in_if.sink    in_ch,
    tto_out_if.source out_ch
);

    tto_item_t   in_item;
    tto_item_t   item;
    tto_result_t res;
    logic        in_ready;
    logic        item_valid;
    logic        take;
    logic        res_valid;

    assign in_item.opt_byte   = in_ch.opt_byte;
    assign in_item.first_byte = in_ch.first_byte;
    assign in_item.area_len   = in_ch.area_len;
    assign in_ch.ready        = in_ready;

    // Input register: holds one byte while the parser waits for room.
    tto_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Option walker with its result register.
    tto_parser #(
        .MAX_AREA (MAX_AREA)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_valid  (res_valid),
        .res_ready  (out_ch.ready),
        .res        (res)
    );

    assign out_ch.valid    = res_valid;
    assign out_ch.found    = res.found;
    assign out_ch.ts_value = res.ts_value;
    assign out_ch.ts_echo  = res.ts_echo;

`ifndef ASSERT_OFF
    // A not-found result always carries zero words.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> ((res.ts_value == 32'd0) && (res.ts_echo == 32'd0)))
        else $error("not-found result with nonzero timestamp words");

    // A full input register that is not consumed must refuse a new transfer.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !take) |-> !in_ready)
        else $error("input register overwritten while held");

    // A new result only appears after the parser consumed a byte.
    a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(take))
        else $error("result appeared without a consumed byte");
`endif

endmodule

`default_nettype wire

### bench/tcp_timestamp_option_parser_top_tb.sv
`default_nettype none

// Testbench for the TCP timestamp option parser.
//
// The sender walks a series of packets through the input channel one option
// byte per transfer. A directed opening covers the empty area, an all-ones value
// word with an all-zeros echo word, end-of-list, no-op, a kind byte that is the
// last area byte, a length below two, an oversized area length, a timestamp
// with the wrong length, a stray byte with no packet and a packet abandoned by
// a new first byte. Random packets follow. Most of them are built from
// well-formed option lists with random content, and the rest carry broken
// lengths, early end-of-list, truncation and noise.
//
// A scoreboard object keeps its own copy of the option walk. On each accepted
// byte it works out whether the packet is decided there and, if so, queues the
// expected result. Every result taken from the output channel is compared
// field by field with the oldest queued result.
module tcp_timestamp_option_parser_top_tb;
    import tto_pkg::*;

    localparam int unsigned MAX_AREA      = 40;
    localparam logic [7:0]  KIND_EOL      = 8'd0;
    localparam logic [7:0]  KIND_NOP      = 8'd1;
    localparam logic [7:0]  KIND_TS       = 8'd8;
    localparam logic [7:0]  TS_LEN        = 8'd10;
    localparam logic [7:0]  MIN_LEN       = 8'd2;
    localparam int          MAX_GAP       = 18;
    localparam int          LONG_HOLD     = 200;
    localparam int          RANDOM_ITEMS  = 450;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          STALL_LIMIT   = 2000;

    // Where the option walk stands within the current packet.
    typedef enum logic [2:0] {
        WALK_IDLE,
        WALK_KIND,
        WALK_LEN_OTHER,
        WALK_LEN_TS,
        WALK_SKIP,
        WALK_GATHER,
        WALK_DONE
    } walk_t;

    // Tracks the option walk and holds the results that the walk predicts.
    class ts_option_scoreboard;
        walk_t       phase;
        logic [5:0]  remaining;
        logic [7:0]  skip_count;
        logic [63:0] ts_gather;
        logic [2:0]  gather_count;
        tto_result_t expected_results[$];
        int          failures;

        function new();
            phase = WALK_IDLE;
            remaining = '0;
            skip_count = '0;
            ts_gather = '0;
            gather_count = '0;
            failures = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Appends one predicted result behind the ones already waiting.
        local function void queue_result(tto_result_t r);
            expected_results = {expected_results, r};
        endfunction

        // The packet is decided without a timestamp.
        local function void give_up();
            queue_result('0);
            phase = WALK_DONE;
        endfunction

        // One option is fully consumed: the area is used up or a kind follows.
        local function void after_option();
            if (remaining == 0)
                give_up();
            else
                phase = WALK_KIND;
        endfunction

        local function void take_kind(logic [7:0] b);
            if (b == KIND_EOL)
            begin
                give_up();
            end
            else if (b == KIND_NOP)
            begin
                remaining = remaining - 6'd1;
                after_option();
            end
            else if (remaining < 2)
            begin
                give_up();
            end
            else
            begin
                phase = (b == KIND_TS) ? WALK_LEN_TS : WALK_LEN_OTHER;
            end
        endfunction

        // Notes one accepted byte. Returns 0 when the block just drops it.
        function bit note_byte(tto_item_t it);
            logic [5:0]  alen;
            tto_result_t hit;
            if (it.first_byte)
            begin
                alen = (it.area_len > MAX_AREA) ? 6'(MAX_AREA) : it.area_len;
                remaining = alen;
                skip_count = '0;
                ts_gather = '0;
                gather_count = '0;
                if (remaining == 0)
                    give_up();
                else
                    take_kind(it.opt_byte);
                return 1'b1;
            end
            case (phase)
                WALK_KIND:
                begin
                    take_kind(it.opt_byte);
                end
                WALK_LEN_OTHER, WALK_LEN_TS:
                begin
                    if (it.opt_byte < MIN_LEN || it.opt_byte > {2'b00, remaining})
                    begin
                        give_up();
                    end
                    else if (phase == WALK_LEN_TS && it.opt_byte == TS_LEN)
                    begin
                        ts_gather = '0;
                        gather_count = '0;
                        phase = WALK_GATHER;
                    end
                    else
                    begin
                        remaining = remaining - it.opt_byte[5:0];
                        skip_count = it.opt_byte - MIN_LEN;
                        if (skip_count != 0)
                            phase = WALK_SKIP;
                        else
                            after_option();
                    end
                end
                WALK_SKIP:
                begin
                    skip_count = skip_count - 8'd1;
                    if (skip_count == 0)
                        after_option();
                end
                WALK_GATHER:
                begin
                    ts_gather = {ts_gather[55:0], it.opt_byte};
                    if (gather_count >= 3'd7)
                    begin
                        hit.found = 1'b1;
                        hit.ts_value = ts_gather[63:32];
                        hit.ts_echo = ts_gather[31:0];
                        queue_result(hit);
                        gather_count = '0;
                        phase = WALK_DONE;
                    end
                    else
                    begin
                        gather_count = gather_count + 3'd1;
                    end
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
            return 1'b1;
        endfunction

        function void check_result(tto_result_t got);
            tto_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b ts_value=%h ts_echo=%h",
                         $time, got.found, got.ts_value, got.ts_echo);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0b, got %0b",
                         $time, want.found, got.found);
                failures++;
            end
            if (got.ts_value !== want.ts_value)
            begin
                $display("%0t: ts_value mismatch, expected %h, got %h",
                         $time, want.ts_value, got.ts_value);
                failures++;
            end
            if (got.ts_echo !== want.ts_echo)
            begin
                $display("%0t: ts_echo mismatch, expected %h, got %h",
                         $time, want.ts_echo, got.ts_echo);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tto_in_if  in_ch();
    tto_out_if out_ch();

    tcp_timestamp_option_parser_top #(
        .MAX_AREA(MAX_AREA)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    ts_option_scoreboard sb = new();

    // Sender pacing. A burst forces back-to-back transfers; a steady stretch
    // does the same for a few packets so that runs without gaps also occur.
    bit hold_request;
    bit tx_burst;
    bit tx_steady;
    int tx_left;
    int live_items;
    int stall_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one byte after a random gap and waits for its transfer. Valid is
    // only lowered when a gap follows, so back-to-back bytes keep it high.
    task automatic send_byte(input logic first, input logic [5:0] alen,
                             input logic [7:0] b);
        int        gap;
        tto_item_t item;
        gap = (tx_burst || tx_steady) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opt_byte   <= b;
        in_ch.first_byte <= first;
        in_ch.area_len   <= alen;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        item = '{opt_byte: b, first_byte: first, area_len: alen};
        if (sb.note_byte(item))
            live_items++;
    endtask

    // Builds one packet's option area and sends it. Most areas are option
    // lists that the parser can walk; some carry broken lengths, an early
    // end-of-list or raw noise. A few packets are cut short, preceded by stray
    // bytes, or given an area length above the limit.
    task automatic send_packet(input bit short_only);
        logic [7:0] area[$];
        int         len;
        int         room;
        int         pick;
        int         olen;
        int         sent;
        int         alen_field;
        if (tx_left == 0)
        begin
            tx_left = $urandom_range(3, 10);
            tx_steady = ($urandom_range(0, 2) == 0);
        end
        tx_left--;

        // Stray bytes while the parser waits for a packet start.
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(1'b0, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end

        pick = $urandom_range(0, 9);
        if (short_only)
            len = $urandom_range(0, 3);
        else if (pick < 6)
            len = $urandom_range(0, 12);
        else if (pick < 9)
            len = $urandom_range(13, 24);
        else
            len = $urandom_range(25, MAX_AREA);

        while (area.size() < len)
        begin
            room = len - area.size();
            pick = $urandom_range(0, 19);
            if (pick < 4)
            begin
                area = {area, KIND_NOP};
            end
            else if (pick < 10 && room >= 10)
            begin
                area = {area, KIND_TS, TS_LEN};
                repeat (8)
                    area = {area, 8'($urandom_range(0, 255))};
            end
            else if (pick < 14 && room >= 2)
            begin
                olen = $urandom_range(2, (room < 12) ? room : 12);
                area = {area, 8'($urandom_range(2, 255)), 8'(olen)};
                repeat (olen - 2)
                    area = {area, 8'($urandom_range(0, 255))};
            end
            else if (pick == 14)
            begin
                area = {area, KIND_EOL};
            end
            else if (pick == 15 && room >= 2)
            begin
                // Timestamp kind with a length the parser must skip instead.
                olen = $urandom_range(2, (room < 12) ? room : 12);
                if (olen == TS_LEN)
                    olen = olen - 1;
                area = {area, KIND_TS, 8'(olen)};
                repeat (olen - 2)
                    area = {area, 8'($urandom_range(0, 255))};
            end
            else if (pick == 16)
            begin
                // A length below two or past the end of the area.
                area = {area, 8'($urandom_range(2, 255))};
                if (room >= 2)
                begin
                    if ($urandom_range(0, 1) == 0)
                        area = {area, 8'($urandom_range(0, 1))};
                    else
                        area = {area, 8'($urandom_range(room + 1, 255))};
                end
            end
            else
            begin
                area = {area, 8'($urandom_range(0, 255))};
            end
        end

        alen_field = len;
        if ((len == MAX_AREA && $urandom_range(0, 1) == 0) || $urandom_range(0, 24) == 0)
            alen_field = $urandom_range(MAX_AREA + 1, 63);

        sent = len;
        if (len >= 2 && $urandom_range(0, 9) == 0)
            sent = $urandom_range(1, len - 1);

        if (len == 0)
        begin
            send_byte(1'b1, 6'd0, 8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int k = 0; k < sent; k++)
            begin
                if (k == 0)
                    send_byte(1'b1, 6'(alen_field), area[k]);
                else
                    send_byte(1'b0, 6'($urandom_range(0, 63)), area[k]);
            end
        end
    endtask

    // Result side. Each result waits a random gap, or none in a steady stretch, before
    // ready rises; a hold request from the sender turns that into one long stall.
    initial
    begin
        int gap;
        int rx_left;
        bit rx_steady;
        tto_result_t got;
        rx_left = 0;
        rx_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_left == 0)
            begin
                rx_left = $urandom_range(5, 20);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            rx_left--;
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            else
            begin
                gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got.found = out_ch.found;
            got.ts_value = out_ch.ts_value;
            got.ts_echo = out_ch.ts_echo;
            sb.check_result(got);
        end
    end

    // The run is stuck if neither channel moves a transfer for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int packets;
        in_ch.valid = 1'b0;
        in_ch.opt_byte = '0;
        in_ch.first_byte = 1'b0;
        in_ch.area_len = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        hold_request = 1'b0;
        tx_burst = 1'b0;
        tx_steady = 1'b0;
        tx_left = 0;
        live_items = 0;
        stall_cycles = 0;
        packets = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty area: a single dummy byte that must still give a result.
        send_byte(1'b1, 6'd0, 8'hFF);
        // Timestamp with an all-ones value word and an all-zeros echo word.
        send_byte(1'b1, 6'd10, KIND_TS);
        send_byte(1'b0, 6'd63, TS_LEN);
        repeat (4) send_byte(1'b0, 6'd0, 8'hFF);
        repeat (4) send_byte(1'b0, 6'd63, 8'h00);
        // A no-op that uses up the area, then an end-of-list.
        send_byte(1'b1, 6'd1, KIND_NOP);
        send_byte(1'b1, 6'd1, KIND_EOL);
        // A kind byte that is the last area byte has no room for its length.
        send_byte(1'b1, 6'd1, 8'd5);
        // Timestamp kind with a length of three is skipped, exhausting the area.
        send_byte(1'b1, 6'd3, KIND_TS);
        send_byte(1'b0, 6'd0, 8'd3);
        send_byte(1'b0, 6'd0, 8'hA5);
        // A length below two ends the walk.
        send_byte(1'b1, 6'd2, 8'd2);
        send_byte(1'b0, 6'd0, 8'd1);
        // An area length of 63 counts as 40, so a length of 41 does not fit.
        send_byte(1'b1, 6'd63, 8'd2);
        send_byte(1'b0, 6'd0, 8'd41);
        // A stray byte while idle is dropped.
        send_byte(1'b0, 6'd40, 8'h80);
        // A new first byte abandons a timestamp in progress.
        send_byte(1'b1, 6'd10, KIND_TS);
        send_byte(1'b0, 6'd0, TS_LEN);
        send_byte(1'b1, 6'd1, KIND_EOL);

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            if (packets == 8)
            begin
                // Short packets back to back while the result side holds off,
                // so that the parser fills up and stalls its input.
                hold_request = 1'b1;
                tx_burst = 1'b1;
                repeat (12) send_packet(1'b1);
                tx_burst = 1'b0;
            end
            if (packets == 20)
            begin
                // Let the parser drain completely before going on.
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_packet(1'b0);
            packets++;
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
